// File: design/drrip_pkg.sv
// Shared types and constants for the DRRIP replacement core.
// Used by drrip_front, drrip_back and drrip_replacement_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drrip_pkg;

	// Geometry
	localparam int NUM_SETS   = 2048;
	localparam int SET_W      = $clog2(NUM_SETS);
	localparam int NUM_WAYS   = 16;
	localparam int WAY_W      = $clog2(NUM_WAYS);
	localparam int RRPV_W     = 2;
	localparam int ROW_W      = NUM_WAYS * RRPV_W;
	localparam logic [RRPV_W-1:0] RRPV_TOP = {RRPV_W{1'b1}};

	// Set dueling
	localparam int SEL_W = 10;
	localparam logic [SEL_W-1:0] SEL_TOP  = {SEL_W{1'b1}};
	localparam logic [SEL_W-1:0] SEL_HALF = SEL_TOP >> 1;
	localparam int LEADERS_PER_POLICY = 32;
	localparam int LEADER_STRIDE_RAW  = NUM_SETS / LEADERS_PER_POLICY;
	localparam int LEADER_STRIDE = (LEADER_STRIDE_RAW < 2) ? 2 : LEADER_STRIDE_RAW;
	localparam int STRIDE_W      = $clog2(LEADER_STRIDE);

	// Bimodal insertion counter: a BIP fill goes in at RRPV 0 once in BIP_PERIOD misses
	localparam int BIP_PERIOD = 32;
	localparam int BIP_W      = $clog2(BIP_PERIOD);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// Action codes
	localparam logic ACT_HIT  = 1'b0;
	localparam logic ACT_MISS = 1'b1;

	// Item class decided at the front
	typedef enum logic [1:0] {
		CLS_HIT,
		CLS_SRRIP_LDR,
		CLS_BIP_LDR,
		CLS_FOLLOW
	} cls_t;

	typedef struct packed {
		logic             action;
		logic [SET_W-1:0] set_index;
		logic [WAY_W-1:0] hit_way;
	} req_t;

	typedef struct packed {
		logic [WAY_W-1:0] victim_way;
		logic             used_bip;
	} rsp_t;

	typedef struct packed {
		cls_t             cls;
		logic [SET_W-1:0] set_index;
		logic [WAY_W-1:0] hit_way;
	} qent_t;

	// Front to back: queue head
	typedef struct packed {
		logic  valid;
		qent_t entry;
	} q2b_t;

	// Back to front: pop and init status
	typedef struct packed {
		logic pop;
		logic init_done;
	} b2q_t;

endpackage

`default_nettype wire

// File: design/drrip_front.sv
// Front end: accepts items, classifies them (hit, leader kind, follower) and queues them.
// Depends on drrip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drrip_front import drrip_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output q2b_t      q2b,
	input  wire b2q_t b2q
);

	qent_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               pop;
	qent_t              new_entry;
	logic [STRIDE_W-1:0] set_off;

	// Hold off items during the init sweep and while the queue is full
	assign busy = !b2q.init_done || (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push = start && !busy;
	assign pop  = b2q.pop && (count_q != '0);

	// Classify the incoming item
	assign set_off = req.set_index[STRIDE_W-1:0];
	always_comb begin
		new_entry.set_index = req.set_index;
		new_entry.hit_way   = req.hit_way;
		if (req.action == ACT_HIT) begin
			new_entry.cls = CLS_HIT;
		end else if (set_off == STRIDE_W'(0)) begin
			new_entry.cls = CLS_SRRIP_LDR;
		end else if (set_off == STRIDE_W'(1)) begin
			new_entry.cls = CLS_BIP_LDR;
		end else begin
			new_entry.cls = CLS_FOLLOW;
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= new_entry;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign q2b.valid = (count_q != '0);
	assign q2b.entry = entries_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: design/drrip_back.sv
// Back end: RRPV row memory, init sweep, aging and victim pick, policy selector.
// Depends on drrip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drrip_back import drrip_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire q2b_t q2b,
	output b2q_t      b2q,
	output logic      done,
	output rsp_t      rsp
);

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t             state_q;
	logic [SET_W-1:0]   init_idx_q;
	qent_t              cur_q;
	logic [SEL_W-1:0]   sel_q;
	logic [BIP_W-1:0]   bip_cnt_q;
	logic               done_q;
	rsp_t               rsp_q;

	logic [ROW_W-1:0]   mem [NUM_SETS];
	logic [ROW_W-1:0]   rdata_q;
	logic               mem_we;
	logic [SET_W-1:0]   mem_waddr;
	logic [ROW_W-1:0]   mem_wdata;
	logic               mem_re;

	logic [RRPV_W-1:0]  rrpv [NUM_WAYS];
	logic [RRPV_TOP:0]  lvl_any;
	logic [RRPV_W-1:0]  top;
	logic [RRPV_W-1:0]  gap;
	logic [RRPV_W:0]    aged_sum;
	logic [ROW_W-1:0]   new_row;
	logic [WAY_W-1:0]   victim;
	logic               use_bip;
	logic [BIP_W-1:0]   bip_next;
	logic [SEL_W-1:0]   sel_next;
	logic [RRPV_W-1:0]  fill_val;

	// Row memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[q2b.entry.set_index];
		end
	end

	// Age the row, pick the victim and work out the fill
	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			rrpv[w] = rdata_q[w*RRPV_W +: RRPV_W];
		end
		for (int l = 0; l <= RRPV_TOP; l++) begin
			lvl_any[l] = 1'b0;
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (rrpv[w] == RRPV_W'(l)) begin
					lvl_any[l] = 1'b1;
				end
			end
		end
		top = '0;
		for (int l = 0; l <= RRPV_TOP; l++) begin
			if (lvl_any[l]) begin
				top = RRPV_W'(l);
			end
		end
		gap = RRPV_TOP - top;
		// lowest way at the current maximum reaches the top after aging
		victim = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (rrpv[w] == top) begin
				victim = WAY_W'(w);
			end
		end

		// Set dueling decision and selector update
		sel_next = sel_q;
		case (cur_q.cls)
			CLS_SRRIP_LDR: begin
				use_bip = 1'b0;
				if (sel_q != SEL_TOP) begin
					sel_next = sel_q + 1'b1;
				end
			end
			CLS_BIP_LDR: begin
				use_bip = 1'b1;
				if (sel_q != '0) begin
					sel_next = sel_q - 1'b1;
				end
			end
			CLS_FOLLOW: begin
				use_bip = (sel_q > SEL_HALF);
			end
			default: begin
				use_bip = 1'b0;
			end
		endcase
		bip_next = (bip_cnt_q == BIP_W'(BIP_PERIOD - 1)) ? '0 : bip_cnt_q + 1'b1;
		if (use_bip) begin
			fill_val = (bip_next == '0) ? '0 : RRPV_TOP;
		end else begin
			fill_val = RRPV_TOP - 1'b1;
		end

		// Build the updated row
		aged_sum = '0;
		new_row  = rdata_q;
		if (cur_q.cls == CLS_HIT) begin
			new_row[cur_q.hit_way*RRPV_W +: RRPV_W] = '0;
		end else begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				aged_sum = {1'b0, rrpv[w]} + {1'b0, gap};
				new_row[w*RRPV_W +: RRPV_W] =
					(aged_sum > {1'b0, RRPV_TOP}) ? RRPV_TOP : aged_sum[RRPV_W-1:0];
			end
			new_row[victim*RRPV_W +: RRPV_W] = fill_val;
		end
	end

	// Memory port control
	always_comb begin
		mem_re    = (state_q == ST_IDLE) && q2b.valid;
		mem_we    = 1'b0;
		mem_waddr = cur_q.set_index;
		mem_wdata = new_row;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = init_idx_q;
				mem_wdata = {NUM_WAYS{RRPV_TOP}};
			end
			ST_EXEC: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Sequence: init sweep, then one item at a time (read, then modify and write)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			init_idx_q <= '0;
			sel_q      <= SEL_HALF;
			bip_cnt_q  <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					init_idx_q <= init_idx_q + 1'b1;
					if (init_idx_q == SET_W'(NUM_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q2b.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					if (cur_q.cls != CLS_HIT) begin
						sel_q     <= sel_next;
						bip_cnt_q <= bip_next;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item and result payload
	always_ff @(posedge clk) begin
		if (mem_re) begin
			cur_q <= q2b.entry;
		end
		if (state_q == ST_EXEC) begin
			if (cur_q.cls == CLS_HIT) begin
				rsp_q.victim_way <= cur_q.hit_way;
				rsp_q.used_bip   <= 1'b0;
			end else begin
				rsp_q.victim_way <= victim;
				rsp_q.used_bip   <= use_bip;
			end
		end
	end

	assign b2q.pop       = mem_re;
	assign b2q.init_done = (state_q != ST_INIT);
	assign done          = done_q;
	assign rsp           = rsp_q;

endmodule

`default_nettype wire

// File: design/drrip_replacement_core.sv
// Top level of the DRRIP replacement core: front (accept, classify, queue) and back (execute).
// Depends on drrip_pkg, drrip_front and drrip_back.
//
// After reset the core sweeps its 2048-row RRPV memory to the all-maximum state with busy
// high. After that an item is taken whenever start is high and busy is low; busy rises
// only while the 4-entry queue is full. The back end handles one item at a time (a registered
// row read, then the aging, victim pick and row write-back), so it cannot take a new item
// before it has written back the last. Every item gives exactly one result, shown for one
// cycle with done high; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

module drrip_replacement_core import drrip_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);

	q2b_t q2b;
	b2q_t b2q;

	// Accept and classify items
	drrip_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.q2b    (q2b),
		.b2q    (b2q)
	);

	// Update RRPV rows and the policy selector
	drrip_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q2b    (q2b),
		.b2q    (b2q),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
